>>> design/rectangle_grid_allocator_assert.svh
// ============================================================================
// Rectangle grid allocator assertion macros
// Shorthand for clocked assertions that are disabled while reset is held.
// ============================================================================
`ifndef RECTANGLE_GRID_ALLOCATOR_ASSERT_SVH
`define RECTANGLE_GRID_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define RGA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rectangle_grid_allocator: assertion failed");

// Next-cycle implication.
`define RGA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rectangle_grid_allocator: assertion failed");

`endif

>>> design/rga_pkg.sv
// ============================================================================
// Rectangle grid allocator package
// Grid geometry, field widths, request and outcome codes and storage types.
// ============================================================================
`default_nettype none

package rga_pkg;

    localparam int GRID_ROWS    = 8;
    localparam int GRID_COLS    = 8;
    localparam int MAX_ITEM_IDS = 256;

    localparam int ROW_W      = $clog2(GRID_ROWS);
    localparam int COL_W      = $clog2(GRID_COLS);
    localparam int ID_W       = $clog2(MAX_ITEM_IDS);
    localparam int SPAN_W     = 4;
    localparam int COUNT_W    = 7;
    localparam int REQ_W      = 2;
    localparam int OUTCOME_W  = 2;
    localparam int CELL_W     = ID_W + 1;
    localparam int ROW_DATA_W = GRID_COLS * CELL_W;
    localparam int PLACE_W    = ROW_W + COL_W + 2 * SPAN_W;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

    localparam logic [OUTCOME_W-1:0] OUT_SUCCESS         = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_ALREADY_PRESENT = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_DOESNT_FIT      = 2'd2;
    localparam logic [OUTCOME_W-1:0] OUT_NOT_PRESENT     = 2'd3;

    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] owner;
    } cell_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [SPAN_W-1:0] height;
        logic [SPAN_W-1:0] width;
    } place_t;

endpackage

`default_nettype wire

>>> design/rga_if.sv
// ============================================================================
// Rectangle grid allocator channels
// Request and response channels with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface rga_req_if
    import rga_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [7:0]        item_id;
    logic [2:0]        anchor_row;
    logic [2:0]        anchor_col;
    logic [SPAN_W-1:0] item_height;
    logic [SPAN_W-1:0] item_width;

    modport source (output valid, req_type, item_id, anchor_row, anchor_col,
                    item_height, item_width, input ready);
    modport sink   (input valid, req_type, item_id, anchor_row, anchor_col,
                    item_height, item_width, output ready);
endinterface

interface rga_rsp_if
    import rga_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [OUTCOME_W-1:0] outcome;
    logic                 cell_owned;
    logic [7:0]           cell_owner;
    logic [COUNT_W-1:0]   item_count;

    modport source (output valid, outcome, cell_owned, cell_owner, item_count,
                    input ready);
    modport sink   (input valid, outcome, cell_owned, cell_owner, item_count,
                    output ready);
endinterface

`default_nettype wire

>>> design/rectangle_grid_allocator.sv
// ============================================================================
// Rectangle grid allocator
// Claims, frees and looks up rectangular regions of an occupancy grid.
// ============================================================================
// The grid is held one row per word in a RAM, with a valid bit per row so that
// reset leaves it empty at once; item places sit in a second RAM with a valid
// bit per item. One item is worked on at a time, and the row RAM sets the pace
// at one row per cycle. An insert makes a check pass over the rows that the
// rectangle covers after clipping and then a write pass, and stops at the
// first row with a conflict; a remove reads the item's place from the table
// and then makes a write pass; a cell read reads one row; and a request that
// is refused at once goes straight to its result. A new item is taken as soon
// as the previous result has been moved into the output register.
`default_nettype none

`include "rectangle_grid_allocator_assert.svh"

module rectangle_grid_allocator
    import rga_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    rga_req_if.sink   req,
    rga_rsp_if.source rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TBL   = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MOD   = 3'd3;
    localparam logic [2:0] S_CELL  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic                    op_ins_reg, op_ins_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic [ROW_W-1:0]        row_start_reg, row_start_next;
    logic [ROW_W-1:0]        cur_row_reg, cur_row_next;
    logic [ROW_W:0]          end_row_reg, end_row_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [SPAN_W-1:0]       height_reg, height_next;
    logic [SPAN_W-1:0]       width_reg, width_next;
    logic [OUTCOME_W-1:0]    res_outcome_reg, res_outcome_next;
    logic                    res_owned_reg, res_owned_next;
    logic [ID_W-1:0]         res_owner_reg, res_owner_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [GRID_ROWS-1:0]    row_valid_reg, row_valid_next;
    logic [MAX_ITEM_IDS-1:0] item_valid_reg, item_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUTCOME_W-1:0]    out_outcome_reg;
    logic                    out_owned_reg;
    logic [ID_W-1:0]         out_owner_reg;
    logic [COUNT_W-1:0]      out_count_reg;

    logic                  grid_wr_en;
    logic [ROW_W-1:0]      grid_rd_addr;
    logic [ROW_DATA_W-1:0] grid_rd_data;
    logic [ROW_DATA_W-1:0] grid_wr_data;
    logic                  tbl_wr_en;
    logic [ID_W-1:0]       tbl_rd_addr;
    logic [PLACE_W-1:0]    tbl_rd_data;
    place_t                tbl_wr_place;
    place_t                tbl_place;

    cell_t                 row_cells [GRID_COLS];
    cell_t                 new_cells [GRID_COLS];
    logic [GRID_COLS-1:0]  col_mask;
    logic [GRID_COLS-1:0]  owned_vec;
    logic                  conflict;
    logic                  last_row;
    logic                  out_free;
    logic                  id_ok;
    logic                  row_ok;
    logic                  col_ok;

    function automatic logic [ROW_W:0] clip_rows(input logic [ROW_W-1:0] start,
                                                 input logic [SPAN_W-1:0] span);
        logic [SPAN_W:0] sum;
        sum = (SPAN_W + 1)'(start) + (SPAN_W + 1)'(span);
        if (sum > (SPAN_W + 1)'(GRID_ROWS))
        begin
            return (ROW_W + 1)'(GRID_ROWS);
        end
        return (ROW_W + 1)'(sum);
    endfunction

    rga_ram #(
        .WIDTH (ROW_DATA_W),
        .DEPTH (GRID_ROWS)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (grid_wr_en),
        .wr_addr (cur_row_reg),
        .wr_data (grid_wr_data),
        .rd_addr (grid_rd_addr),
        .rd_data (grid_rd_data)
    );

    rga_ram #(
        .WIDTH (PLACE_W),
        .DEPTH (MAX_ITEM_IDS)
    ) u_place_ram (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (id_reg),
        .wr_data (tbl_wr_place),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    assign tbl_place    = place_t'(tbl_rd_data);
    assign tbl_wr_place = '{row: row_start_reg, col: col_reg,
                            height: height_reg, width: width_reg};

    assign id_ok  = 32'(req.item_id) < MAX_ITEM_IDS;
    assign row_ok = 32'(req.anchor_row) < GRID_ROWS;
    assign col_ok = 32'(req.anchor_col) < GRID_COLS;

    always_comb
    begin
        for (int j = 0; j < GRID_COLS; j++)
        begin
            col_mask[j] = (7'(j) >= 7'(col_reg)) &&
                          (7'(j) < 7'(col_reg) + 7'(width_reg));
            row_cells[j] = row_valid_reg[cur_row_reg] ?
                           cell_t'(grid_rd_data[j*CELL_W +: CELL_W]) : '0;
            owned_vec[j] = row_cells[j].valid;
            if (!col_mask[j])
            begin
                new_cells[j] = row_cells[j];
            end
            else if (op_ins_reg)
            begin
                new_cells[j] = '{valid: 1'b1, owner: id_reg};
            end
            else
            begin
                new_cells[j] = '0;
            end
            grid_wr_data[j*CELL_W +: CELL_W] = new_cells[j];
        end
    end

    assign conflict = |(col_mask & owned_vec);
    assign last_row = ((ROW_W + 1)'(cur_row_reg) + 1'b1) == end_row_reg;
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next       = state_reg;
        op_ins_next      = op_ins_reg;
        id_next          = id_reg;
        row_start_next   = row_start_reg;
        cur_row_next     = cur_row_reg;
        end_row_next     = end_row_reg;
        col_next         = col_reg;
        height_next      = height_reg;
        width_next       = width_reg;
        res_outcome_next = res_outcome_reg;
        res_owned_next   = res_owned_reg;
        res_owner_next   = res_owner_reg;
        count_next       = count_reg;
        row_valid_next   = row_valid_reg;
        item_valid_next  = item_valid_reg;
        grid_wr_en       = 1'b0;
        tbl_wr_en        = 1'b0;
        grid_rd_addr     = cur_row_reg + 1'b1;
        tbl_rd_addr      = ID_W'(req.item_id);
        req.ready        = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                grid_rd_addr = ROW_W'(req.anchor_row);
                if (req.valid)
                begin
                    id_next          = ID_W'(req.item_id);
                    row_start_next   = ROW_W'(req.anchor_row);
                    cur_row_next     = ROW_W'(req.anchor_row);
                    col_next         = COL_W'(req.anchor_col);
                    height_next      = req.item_height;
                    width_next       = req.item_width;
                    end_row_next     = clip_rows(ROW_W'(req.anchor_row), req.item_height);
                    res_outcome_next = OUT_SUCCESS;
                    res_owned_next   = 1'b0;
                    res_owner_next   = '0;
                    state_next       = S_FIN;
                    unique case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (id_ok && item_valid_reg[ID_W'(req.item_id)])
                            begin
                                res_outcome_next = OUT_ALREADY_PRESENT;
                            end
                            else if (!id_ok || req.item_height == '0 ||
                                     req.item_width == '0 || !row_ok || !col_ok)
                            begin
                                res_outcome_next = OUT_DOESNT_FIT;
                            end
                            else
                            begin
                                op_ins_next = 1'b1;
                                state_next  = S_CHECK;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (!id_ok || !item_valid_reg[ID_W'(req.item_id)])
                            begin
                                res_outcome_next = OUT_NOT_PRESENT;
                            end
                            else
                            begin
                                op_ins_next = 1'b0;
                                state_next  = S_TBL;
                            end
                        end
                        REQ_READ:
                        begin
                            if (row_ok && col_ok)
                            begin
                                state_next = S_CELL;
                            end
                        end
                        default:
                        begin
                            state_next = S_FIN;
                        end
                    endcase
                end
            end
            S_TBL:
            begin
                row_start_next = tbl_place.row;
                cur_row_next   = tbl_place.row;
                col_next       = tbl_place.col;
                height_next    = tbl_place.height;
                width_next     = tbl_place.width;
                end_row_next   = clip_rows(tbl_place.row, tbl_place.height);
                grid_rd_addr   = tbl_place.row;
                state_next     = S_MOD;
            end
            S_CHECK:
            begin
                if (conflict)
                begin
                    res_outcome_next = OUT_DOESNT_FIT;
                    state_next       = S_FIN;
                end
                else if (last_row)
                begin
                    grid_rd_addr = row_start_reg;
                    cur_row_next = row_start_reg;
                    state_next   = S_MOD;
                end
                else
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            S_MOD:
            begin
                grid_wr_en                  = 1'b1;
                row_valid_next[cur_row_reg] = 1'b1;
                if (last_row)
                begin
                    item_valid_next[id_reg] = op_ins_reg;
                    if (op_ins_reg)
                    begin
                        tbl_wr_en  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else if (count_reg != '0)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    res_outcome_next = OUT_SUCCESS;
                    state_next       = S_FIN;
                end
                else
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            S_CELL:
            begin
                res_owned_next = row_cells[col_reg].valid;
                res_owner_next = row_cells[col_reg].valid ? row_cells[col_reg].owner : '0;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (state_reg == S_FIN && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            row_valid_reg  <= '0;
            item_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            row_valid_reg  <= row_valid_next;
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_ins_reg      <= op_ins_next;
        id_reg          <= id_next;
        row_start_reg   <= row_start_next;
        cur_row_reg     <= cur_row_next;
        end_row_reg     <= end_row_next;
        col_reg         <= col_next;
        height_reg      <= height_next;
        width_reg       <= width_next;
        res_outcome_reg <= res_outcome_next;
        res_owned_reg   <= res_owned_next;
        res_owner_reg   <= res_owner_next;
        if (state_reg == S_FIN && out_free)
        begin
            out_outcome_reg <= res_outcome_reg;
            out_owned_reg   <= res_owned_reg;
            out_owner_reg   <= res_owner_reg;
            out_count_reg   <= count_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.outcome    = out_outcome_reg;
    assign rsp.cell_owned = out_owned_reg;
    assign rsp.cell_owner = 8'(out_owner_reg);
    assign rsp.item_count = out_count_reg;

    // Every stored item holds at least one cell, so the count cannot pass the cell total.
    `RGA_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= COUNT_W'(GRID_ROWS * GRID_COLS))
    // The item count only moves when the last row of a write pass is committed.
    `RGA_ASSERT_IMP(a_count_source, count_reg != $past(count_reg), $past(state_reg) == S_MOD)
    // An accepted item keeps the block busy in the following cycle.
    `RGA_ASSERT_NXT(a_accept_busy, req.valid && req.ready, state_reg != S_IDLE)

endmodule

`default_nettype wire

>>> design/rga_ram.sv
// ============================================================================
// Rectangle grid allocator RAM
// Generic memory with one write port and one registered read port.
// ============================================================================
`default_nettype none

module rga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
